// File: design/dpwp_pkg.sv
// Shared types and constants for the depth pixel to world point pipeline.
`timescale 1ns / 1ps

package dpwp_pkg;

  // Field widths fixed by the stream format.
  localparam int unsigned PIX_W   = 12;
  localparam int unsigned DEPTH_W = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned IFOC_W  = 24;
  localparam int unsigned CTR_W   = 16;
  localparam int unsigned ROT_W   = 16;
  localparam int unsigned ROWP_W  = 48;
  localparam int unsigned TRN_W   = 21;
  localparam int unsigned TRNP_W  = 63;
  localparam int unsigned WORLD_W = 24;

  // Intermediate widths that do not depend on the depth width.
  localparam int unsigned DX_W = 17;             // col*16 - cx, signed
  localparam int unsigned PX_W = DX_W + IFOC_W;  // dx * inv_focal, signed

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW0    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW1    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_ROW2    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSLATION = 3'd7;

  // Register reset values.
  localparam logic [IFOC_W-1:0] RST_INV_FOCAL = 24'd31957;
  localparam logic [CTR_W-1:0]  RST_CENTER_X  = 16'd5112;
  localparam logic [CTR_W-1:0]  RST_CENTER_Y  = 16'd3832;
  localparam logic [ROWP_W-1:0] RST_ROT_ROW0  = 48'h0000_0000_4000;
  localparam logic [ROWP_W-1:0] RST_ROT_ROW1  = 48'h0000_4000_0000;
  localparam logic [ROWP_W-1:0] RST_ROT_ROW2  = 48'h4000_0000_0000;
  localparam logic [TRNP_W-1:0] RST_TRANS     = '0;

  // Pixel colour carried alongside the arithmetic.
  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
  } colour_t;

  // Camera intrinsics.
  typedef struct packed {
    logic [IFOC_W-1:0] inv_focal_x;
    logic [IFOC_W-1:0] inv_focal_y;
    logic [CTR_W-1:0]  center_x;
    logic [CTR_W-1:0]  center_y;
  } cam_cfg_t;

  // Camera to world pose.
  typedef struct packed {
    logic [2:0][ROWP_W-1:0] rot_row;
    logic [TRNP_W-1:0]      trans;
  } pose_cfg_t;

endpackage

// File: design/dpwp_backproj.sv
// Back-projection stages: pixel and depth to a camera-frame point in Q.8 mm.
`timescale 1ns / 1ps

module dpwp_backproj
  import dpwp_pkg::*;
#(
  parameter int unsigned DEPTH_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  cam_cfg_t                         cam,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [PIX_W-1:0]                 pixel_col,
  input  logic [PIX_W-1:0]                 pixel_row,
  input  logic [DEPTH_BITS-1:0]            depth,
  input  logic [BYTE_W-1:0]                mask_value,
  input  colour_t                          colour_in,
  output logic                             pt_valid,
  input  logic                             pt_ready,
  output logic signed [DEPTH_BITS+20:0]    pc_x,
  output logic signed [DEPTH_BITS+20:0]    pc_y,
  output logic signed [DEPTH_BITS+20:0]    pc_z,
  output colour_t                          colour_out
);

  localparam int unsigned QW  = PX_W + DEPTH_BITS;  // dx * ifx * d
  localparam int unsigned PCW = QW - 20;            // after rounding shift
  localparam logic signed [QW:0] QHALF = {{(QW - 19){1'b0}}, 1'b1, 19'b0};

  // Stage valid bits and flow control.
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4     = ~v4_r | pt_ready;
  assign rdy3     = ~v3_r | rdy4;
  assign rdy2     = ~v2_r | rdy3;
  assign rdy1     = ~v1_r | rdy2;
  assign in_ready = rdy1;
  assign pt_valid = v4_r;

  // Stage 1: offsets from the principal point.
  logic signed [DX_W-1:0]   dx_r, dy_r;
  logic [DEPTH_BITS-1:0]    d1_r;
  colour_t                  c1_r;
  logic signed [DX_W-1:0]   dx_nxt, dy_nxt;

  assign dx_nxt = $signed({1'b0, pixel_col, 4'b0}) - $signed({1'b0, cam.center_x});
  assign dy_nxt = $signed({1'b0, pixel_row, 4'b0}) - $signed({1'b0, cam.center_y});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      // A pixel with a zero mask byte is taken and dropped here.
      v1_r <= in_valid & (mask_value != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
      d1_r <= depth;
      c1_r <= colour_in;
    end
  end

  // Stage 2: scale the offsets by the reciprocal focal lengths.
  logic signed [PX_W-1:0]   px_r, py_r;
  logic [DEPTH_BITS-1:0]    d2_r;
  colour_t                  c2_r;
  logic signed [PX_W:0]     px_full, py_full;

  assign px_full = dx_r * $signed({1'b0, cam.inv_focal_x});
  assign py_full = dy_r * $signed({1'b0, cam.inv_focal_y});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      px_r <= px_full[PX_W-1:0];
      py_r <= py_full[PX_W-1:0];
      d2_r <= d1_r;
      c2_r <= c1_r;
    end
  end

  // Stage 3: multiply by depth.
  logic signed [QW-1:0]     qx_r, qy_r;
  logic [DEPTH_BITS-1:0]    d3_r;
  colour_t                  c3_r;
  logic signed [QW:0]       qx_full, qy_full;

  assign qx_full = px_r * $signed({1'b0, d2_r});
  assign qy_full = py_r * $signed({1'b0, d2_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      qx_r <= qx_full[QW-1:0];
      qy_r <= qy_full[QW-1:0];
      d3_r <= d2_r;
      c3_r <= c2_r;
    end
  end

  // Stage 4: round to Q.8 mm, halves going upwards; z is depth times 256.
  logic signed [PCW-1:0]    pcx_r, pcy_r, pcz_r;
  colour_t                  c4_r;
  logic signed [QW:0]       qx_rnd, qy_rnd;

  assign qx_rnd = $signed({qx_r[QW-1], qx_r}) + QHALF;
  assign qy_rnd = $signed({qy_r[QW-1], qy_r}) + QHALF;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (rdy4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      pcx_r <= qx_rnd[QW-1:20];
      pcy_r <= qy_rnd[QW-1:20];
      pcz_r <= {{(PCW - DEPTH_BITS - 8){1'b0}}, d3_r, 8'b0};
      c4_r  <= c3_r;
    end
  end

  assign pc_x       = pcx_r;
  assign pc_y       = pcy_r;
  assign pc_z       = pcz_r;
  assign colour_out = c4_r;

endmodule

// File: design/dpwp_xform.sv
// Rigid transform stages: rotate, round, translate and saturate to 24 bits.
`timescale 1ns / 1ps

module dpwp_xform
  import dpwp_pkg::*;
#(
  parameter int unsigned DEPTH_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pose_cfg_t                      pose,
  input  logic                           pt_valid,
  output logic                           pt_ready,
  input  logic signed [DEPTH_BITS+20:0]  pc_x,
  input  logic signed [DEPTH_BITS+20:0]  pc_y,
  input  logic signed [DEPTH_BITS+20:0]  pc_z,
  input  colour_t                        colour_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0][WORLD_W-1:0]        world,
  output colour_t                        colour_out
);

  localparam int unsigned PCW = DEPTH_BITS + 21;
  localparam int unsigned MW  = PCW + ROT_W;   // one rotation product
  localparam int unsigned AW  = MW + 2;        // sum of three products
  localparam int unsigned SW  = AW - 22;       // after the rounding shift
  localparam int unsigned WW  = SW + 1;        // with translation added
  localparam logic signed [AW-1:0] AHALF = {{(AW - 22){1'b0}}, 1'b1, 21'b0};
  localparam logic signed [WW-1:0] SAT_MAX = {{(WW - 23){1'b0}}, {23{1'b1}}};
  localparam logic signed [WW-1:0] SAT_MIN = {{(WW - 23){1'b1}}, {23{1'b0}}};

  logic v5_r, v6_r, v7_r;
  logic rdy5, rdy6, rdy7;

  assign rdy7      = ~v7_r | out_ready;
  assign rdy6      = ~v6_r | rdy7;
  assign rdy5      = ~v5_r | rdy6;
  assign pt_ready  = rdy5;
  assign out_valid = v7_r;

  // Stage 5: the nine rotation products.
  logic signed [MW-1:0]  prod_r [3][3];
  logic signed [MW-1:0]  prod_nxt [3][3];
  logic signed [PCW-1:0] pc [3];
  colour_t               c5_r;

  assign pc[0] = pc_x;
  assign pc[1] = pc_y;
  assign pc[2] = pc_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        prod_nxt[i][k] = $signed(pose.rot_row[i][ROT_W*k +: ROT_W]) * pc[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (rdy5) begin
      v5_r <= pt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      prod_r <= prod_nxt;
      c5_r   <= colour_in;
    end
  end

  // Stage 6: sum each row and add the rounding half.
  logic signed [AW-1:0] acc_r [3];
  logic signed [AW-1:0] acc_nxt [3];
  colour_t              c6_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_nxt[i] = $signed({{2{prod_r[i][0][MW-1]}}, prod_r[i][0]})
                 + $signed({{2{prod_r[i][1][MW-1]}}, prod_r[i][1]})
                 + $signed({{2{prod_r[i][2][MW-1]}}, prod_r[i][2]})
                 + AHALF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (rdy6) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy6) begin
      acc_r <= acc_nxt;
      c6_r  <= c5_r;
    end
  end

  // Stage 7: shift down to mm, add translation and saturate.
  logic [2:0][WORLD_W-1:0] world_r;
  logic [2:0][WORLD_W-1:0] world_nxt;
  logic signed [WW-1:0]    wsum [3];
  colour_t                 c7_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wsum[i] = $signed({acc_r[i][AW-1], acc_r[i][AW-1:22]})
              + $signed({{(WW - TRN_W){pose.trans[TRN_W*i + TRN_W - 1]}},
                         pose.trans[TRN_W*i +: TRN_W]});
      if (wsum[i] > SAT_MAX) begin
        world_nxt[i] = SAT_MAX[WORLD_W-1:0];
      end else if (wsum[i] < SAT_MIN) begin
        world_nxt[i] = SAT_MIN[WORLD_W-1:0];
      end else begin
        world_nxt[i] = wsum[i][WORLD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (rdy7) begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy7) begin
      world_r <= world_nxt;
      c7_r    <= c6_r;
    end
  end

  assign world      = world_r;
  assign colour_out = c7_r;

endmodule

// File: design/depth_pixel_to_world_point_core.sv
// Seven registered stages run from an accepted pixel to out_tvalid: offsets,
// focal scaling, depth multiply, rounding, rotation products, row sums, and
// translation with saturation. One pixel per cycle unless out_tready stalls.
// Pixels with a zero mask byte are accepted and produce no item.
// Reset (synchronous, active low) clears all stage valid bits and reloads the
// camera and pose registers with their defaults; no clearing pass is needed.
`timescale 1ns / 1ps

module depth_pixel_to_world_point_core
  import dpwp_pkg::*;
#(
  parameter int unsigned DEPTH_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // pixel_col[11:0], pixel_row[23:12], depth_mm[39:24], mask_value[47:40],
  // blue_in[55:48], green_in[63:56], red_in[71:64]
  input  logic [71:0]           in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // world_x[23:0], world_y[47:24], world_z[71:48], red_out[79:72],
  // green_out[87:80], blue_out[95:88]
  output logic [95:0]           out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [TRNP_W-1:0]     cfg_wdata
);

  // Configuration registers.
  cam_cfg_t  cam_r;
  pose_cfg_t pose_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_r.inv_focal_x <= RST_INV_FOCAL;
      cam_r.inv_focal_y <= RST_INV_FOCAL;
      cam_r.center_x    <= RST_CENTER_X;
      cam_r.center_y    <= RST_CENTER_Y;
      pose_r.rot_row[0] <= RST_ROT_ROW0;
      pose_r.rot_row[1] <= RST_ROT_ROW1;
      pose_r.rot_row[2] <= RST_ROT_ROW2;
      pose_r.trans      <= RST_TRANS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INV_FOCAL_X: cam_r.inv_focal_x <= cfg_wdata[IFOC_W-1:0];
        CFG_INV_FOCAL_Y: cam_r.inv_focal_y <= cfg_wdata[IFOC_W-1:0];
        CFG_CENTER_X:    cam_r.center_x    <= cfg_wdata[CTR_W-1:0];
        CFG_CENTER_Y:    cam_r.center_y    <= cfg_wdata[CTR_W-1:0];
        CFG_ROT_ROW0:    pose_r.rot_row[0] <= cfg_wdata[ROWP_W-1:0];
        CFG_ROT_ROW1:    pose_r.rot_row[1] <= cfg_wdata[ROWP_W-1:0];
        CFG_ROT_ROW2:    pose_r.rot_row[2] <= cfg_wdata[ROWP_W-1:0];
        CFG_TRANSLATION: pose_r.trans      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input unpacking; colour is reordered to RGB in the struct.
  colour_t                     colour_in;
  logic [DEPTH_W-1:0]          depth_mm;

  assign depth_mm        = in_tdata[39:24];
  assign colour_in.blue  = in_tdata[55:48];
  assign colour_in.green = in_tdata[63:56];
  assign colour_in.red   = in_tdata[71:64];

  logic                           pt_valid, pt_ready;
  logic signed [DEPTH_BITS+20:0]  pc_x, pc_y, pc_z;
  colour_t                        pt_colour;

  dpwp_backproj #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_backproj (
    .clk        (clk),
    .rst_n      (rst_n),
    .cam        (cam_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .pixel_col  (in_tdata[11:0]),
    .pixel_row  (in_tdata[23:12]),
    .depth      (depth_mm[DEPTH_BITS-1:0]),
    .mask_value (in_tdata[47:40]),
    .colour_in  (colour_in),
    .pt_valid   (pt_valid),
    .pt_ready   (pt_ready),
    .pc_x       (pc_x),
    .pc_y       (pc_y),
    .pc_z       (pc_z),
    .colour_out (pt_colour)
  );

  logic [2:0][WORLD_W-1:0] world;
  colour_t                 out_colour;

  dpwp_xform #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_xform (
    .clk        (clk),
    .rst_n      (rst_n),
    .pose       (pose_r),
    .pt_valid   (pt_valid),
    .pt_ready   (pt_ready),
    .pc_x       (pc_x),
    .pc_y       (pc_y),
    .pc_z       (pc_z),
    .colour_in  (pt_colour),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .world      (world),
    .colour_out (out_colour)
  );

  // Output packing.
  assign out_tdata = {out_colour.blue, out_colour.green, out_colour.red,
                      world[2], world[1], world[0]};

endmodule
